### rtl/core/lge_pkg.sv
// Package for the loss and gradient engine: widths, mode codes and the log table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lge_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int LOG_DEPTH_DEF = 1024;
    localparam int DATA_W = 32;
    localparam int ACC_W = 48;
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_MSE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MAE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BCE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CCE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HUB = 3'd4;
    localparam logic [63:0] LN2_Q32 = 64'd2977044472;

    // Natural log of (1 + i/depth) scaled by 2^frac, by truncated squaring log2 times ln 2.
    function automatic logic [31:0] log_entry(input int i, input int depth, input int frac);
        logic [63:0] x;
        logic [63:0] lg;
        logic [127:0] pr;
        x = ((64'(depth) + 64'(i)) << 30) / 64'(depth);
        lg = '0;
        for (int b = 1; b <= 32; b++) begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30)) begin
                x = x >> 1;
                lg = lg | (64'd1 << (32 - b));
            end
        end
        pr = 128'(lg) * 128'(LN2_Q32) + (128'd1 << (63 - frac));
        return pr[64-frac +: 32];
    endfunction
endpackage
`default_nettype wire

### rtl/core/lge_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface lge_req_if;
    logic valid;
    logic ready;
    logic signed [31:0] prediction;
    logic signed [31:0] target;
    logic last_element;
    modport source(output valid, prediction, target, last_element, input ready);
    modport sink(input valid, prediction, target, last_element, output ready);
endinterface

interface lge_res_if;
    logic valid;
    logic ready;
    logic signed [31:0] gradient;
    logic signed [47:0] loss_total;
    logic last;
    logic saturated;
    modport source(output valid, gradient, loss_total, last, saturated, input ready);
    modport sink(input valid, gradient, loss_total, last, saturated, output ready);
endinterface

interface lge_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/core/loss_and_gradient_engine.sv
// Top level of the loss and gradient engine: sequencer, log table and accumulator.
// Depends on lge_pkg, lge_if, lge_mul and lge_div.
`timescale 1ns / 1ps
`default_nettype none
// One request is taken at a time. After acceptance the engine passes S_M0; MAE and unused
// mode codes then go to S_FIN, MSE and Huber through S_M4, categorical cross entropy through
// S_LN1, S_LN2, S_M1 and S_M2, and binary cross entropy on through S_M3, S_M4 and the 96-step
// restoring divider that forms the gradient (S_DIV, S_DW). From S_FIN the engine passes S_OUT
// back to idle before the next request is accepted. The result is held in an output
// register until taken; a result still waiting there holds the engine at its final step.
// The log table is a constant and needs no clearing.
module loss_and_gradient_engine #(
    parameter int FRAC_BITS = lge_pkg::FRAC_BITS_DEF,
    parameter int LOG_TABLE_DEPTH = lge_pkg::LOG_DEPTH_DEF
) (
    input wire i_clk,
    input wire i_rst_n,
    lge_req_if.sink i_req,
    lge_res_if.source o_res,
    lge_cfg_if.sink i_cfg
);
    import lge_pkg::*;
    localparam int LW = $clog2(LOG_TABLE_DEPTH);
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic [63:0] LN2F = (LN2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

    localparam logic [3:0] S_IDLE = 4'd0, S_LN1 = 4'd1, S_LN2 = 4'd2, S_M1 = 4'd3,
        S_M2 = 4'd4, S_M3 = 4'd5, S_M4 = 4'd6, S_DIV = 4'd7, S_DW = 4'd8,
        S_FIN = 4'd9, S_OUT = 4'd10, S_M0 = 4'd11;

    logic [3:0] r_st, n_st;
    logic [MODE_W-1:0] r_mode;
    logic signed [63:0] r_p, r_t, r_pc, r_term, r_grad, r_ln1, r_ln2;
    logic r_last;
    logic signed [ACC_W-1:0] r_acc;
    logic [31:0] r_lut;
    logic [31:0] w_lnv;
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_mp;
    logic w_dstart, w_ddone;
    logic [95:0] w_quot;
    logic [31:0] r_og;
    logic signed [ACC_W-1:0] r_ol;
    logic r_olast, r_osat, r_ovalid;
    logic r_neg;

    logic [31:0] rom [LOG_TABLE_DEPTH];
    always_comb begin
        for (int i = 0; i < LOG_TABLE_DEPTH; i++) rom[i] = log_entry(i, LOG_TABLE_DEPTH, FRAC_BITS);
    end

    // Log input: leading one position and table index.
    logic [4:0] w_k;
    logic [31:0] w_fq;
    logic [LW-1:0] w_idx;
    always_comb begin
        w_k = '0;
        for (int b = 1; b < 32; b++) if (w_lnv[b]) w_k = 5'(b);
        w_fq = w_lnv << (6'd32 - {1'b0, w_k});
        w_idx = w_fq[31 -: LW];
    end
    logic [4:0] r_kq;
    logic signed [63:0] w_lnres;
    assign w_lnres = $signed({32'd0, r_lut}) +
        ($signed({59'd0, r_kq}) - 64'(FRAC_BITS)) * $signed(LN2F);

    logic signed [63:0] w_one_m_p;
    assign w_one_m_p = ONE - r_pc;
    assign w_lnv = (r_st == S_LN1) ? r_pc[31:0] : w_one_m_p[31:0];

    logic signed [63:0] w_d;
    logic [63:0] w_ad;
    assign w_d = r_p - r_t;
    assign w_ad = w_d[63] ? -w_d : w_d;

    // Multiplier operands per step.
    logic signed [63:0] w_sa, w_sb;
    always_comb begin
        w_sa = w_d; w_sb = w_d;
        case (r_st)
            S_M1: begin w_sa = r_t; w_sb = r_ln1; end
            S_M2: begin w_sa = ONE - r_t; w_sb = r_ln2; end
            S_M3: begin w_sa = r_pc; w_sb = w_one_m_p; end
            default: begin w_sa = w_d; w_sb = w_d; end
        endcase
        w_ma = w_sa[63] ? 32'(-w_sa) : w_sa[31:0];
        w_mb = w_sb[63] ? 32'(-w_sb) : w_sb[31:0];
    end
    logic r_msgn;
    logic signed [63:0] w_mq;
    assign w_mq = r_msgn ? -$signed(w_mp >> FRAC_BITS) : $signed(w_mp >> FRAC_BITS);

    lge_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_mp));
    logic [63:0] r_den;
    logic [63:0] w_e;
    logic [95:0] w_num;
    assign w_e = r_pc - r_t;
    assign w_num = 96'(w_e[63] ? -w_e : w_e) << (2 * FRAC_BITS);
    assign w_dstart = (r_st == S_DIV);
    lge_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_num), .i_den(r_den), .o_done(w_ddone), .o_quot(w_quot));

    logic signed [ACC_W+1:0] w_sum;
    logic signed [63:0] w_gc;
    logic w_gs, w_ss;
    logic signed [ACC_W-1:0] w_sumc;
    assign w_sum = (ACC_W+2)'(r_acc) + (ACC_W+2)'(r_term);
    always_comb begin
        w_gs = 1'b0; w_ss = 1'b0; w_gc = r_grad; w_sumc = w_sum[ACC_W-1:0];
        if (r_grad > 64'sd2147483647) begin w_gc = 64'sd2147483647; w_gs = 1'b1; end
        if (r_grad < -64'sd2147483648) begin w_gc = -64'sd2147483648; w_gs = 1'b1; end
        if (w_sum > $signed({2'b0, 1'b0, {(ACC_W-1){1'b1}}})) begin
            w_sumc = {1'b0, {(ACC_W-1){1'b1}}}; w_ss = 1'b1;
        end
        if (w_sum < $signed({2'b11, 1'b1, {(ACC_W-1){1'b0}}})) begin
            w_sumc = {1'b1, {(ACC_W-1){1'b0}}}; w_ss = 1'b1;
        end
    end

    logic w_fin_go;
    assign w_fin_go = (r_st == S_FIN) && (!r_ovalid || o_res.ready);

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_req.valid) n_st = S_M0;
            S_M0: begin
                case (r_mode)
                    MODE_BCE, MODE_CCE: n_st = S_LN1;
                    MODE_MSE, MODE_HUB: n_st = S_M4;
                    default: n_st = S_FIN;
                endcase
            end
            S_LN1: n_st = S_LN2;
            S_LN2: n_st = S_M1;
            S_M1: n_st = S_M2;
            S_M2: n_st = (r_mode == MODE_BCE) ? S_M3 : S_FIN;
            S_M3: n_st = S_M4;
            S_M4: n_st = (r_mode == MODE_BCE) ? S_DIV : S_FIN;
            S_DIV: n_st = S_DW;
            S_DW: if (w_ddone) n_st = S_FIN;
            S_FIN: if (w_fin_go) n_st = S_OUT;
            S_OUT: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lut <= rom[w_idx];
        r_kq <= w_k;
        r_msgn <= w_sa[63] ^ w_sb[63];
        case (r_st)
            S_IDLE: begin
                r_p <= 64'(i_req.prediction); r_t <= 64'(i_req.target);
                r_last <= i_req.last_element; r_term <= '0; r_grad <= '0;
            end
            S_M0: begin
                if (r_mode == MODE_BCE) begin
                    r_pc <= (r_p < 64'sd1) ? 64'sd1 : ((r_p > ONE - 1) ? ONE - 1 : r_p);
                end else begin
                    r_pc <= (r_p < 64'sd1) ? 64'sd1 : r_p;
                end
                case (r_mode)
                    MODE_MSE: r_grad <= w_d;
                    MODE_MAE: begin
                        r_term <= $signed(w_ad);
                        r_grad <= w_d[63] ? -ONE : (w_d == 0 ? 64'sd0 : ONE);
                    end
                    MODE_CCE: r_grad <= w_d;
                    MODE_HUB: begin
                        if (w_ad > ONE) begin
                            r_term <= $signed(w_ad) - (ONE >>> 1);
                            r_grad <= w_d[63] ? -ONE : ONE;
                        end else r_grad <= w_d;
                    end
                    default: r_grad <= '0;
                endcase
            end
            S_LN1: ;
            S_LN2: r_ln1 <= w_lnres;
            S_M1: r_ln2 <= w_lnres;
            S_M2: r_term <= -w_mq;
            S_M3: if (r_mode == MODE_BCE) r_term <= r_term - w_mq;
            S_M4: begin
                if (r_mode == MODE_BCE) r_den <= w_mp;
                else if (!(r_mode == MODE_HUB && w_ad > ONE))
                    r_term <= $signed(w_mp >> (FRAC_BITS + 1));
                r_neg <= w_e[63];
            end
            S_DW: if (w_ddone) begin
                r_grad <= r_neg ? -$signed(64'(w_quot[95:33] != 0 ? 96'(64'd1 << 33) : w_quot))
                                : $signed(64'(w_quot[95:33] != 0 ? 96'(64'd1 << 33) : w_quot));
            end
            default: ;
        endcase
        if (w_fin_go) begin
            r_og <= w_gc[31:0];
            r_ol <= r_last ? w_sumc : '0;
            r_olast <= r_last;
            r_osat <= w_gs | w_ss;
        end
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_mode <= MODE_MSE; r_acc <= '0; r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg.valid) r_mode <= i_cfg.data;
            if (w_fin_go) begin
                r_acc <= r_last ? '0 : w_sumc;
                r_ovalid <= 1'b1;
            end else if (o_res.ready) r_ovalid <= 1'b0;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_st == S_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.gradient = r_og;
    assign o_res.loss_total = r_ol;
    assign o_res.last = r_olast;
    assign o_res.saturated = r_osat;

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !i_req.ready) else $error("ready while busy");
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_FIN) |=> r_ovalid) else $error("result not posted");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_go && r_last) |=> (r_acc == '0)) else $error("sum not cleared");
endmodule
`default_nettype wire

### rtl/core/lge_div.sv
// Restoring divider, one quotient bit per cycle: floor(num / den).
// Depends on lge_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lge_div (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_start,
    input  wire [95:0] i_num,
    input  wire [63:0] i_den,
    output logic       o_done,
    output logic [95:0] o_quot
);
    import lge_pkg::*;
    logic [95:0] r_q, n_q;
    logic [64:0] r_r, n_r;
    logic [6:0] r_cnt, n_cnt;
    logic r_busy, n_busy, r_done;
    logic [64:0] w_sh;
    always_comb begin
        n_q = r_q; n_r = r_r; n_cnt = r_cnt; n_busy = r_busy;
        w_sh = {r_r[63:0], r_q[95]};
        if (i_start) begin
            n_q = i_num; n_r = '0; n_cnt = 7'd96; n_busy = 1'b1;
        end else if (r_busy) begin
            n_q = {r_q[94:0], 1'b0};
            if (w_sh >= {1'b0, i_den}) begin
                n_r = w_sh - {1'b0, i_den};
                n_q[0] = 1'b1;
            end else begin
                n_r = w_sh;
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) n_busy = 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        r_q <= n_q; r_r <= n_r; r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && (r_cnt == 7'd1);
        end
    end
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

### rtl/core/lge_mul.sv
// Shared registered 32x32 unsigned multiplier.
// Depends on lge_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lge_mul (
    input  wire        i_clk,
    input  wire [31:0] i_a,
    input  wire [31:0] i_b,
    output logic [63:0] o_p
);
    import lge_pkg::*;
    logic [63:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end
    assign o_p = r_p;
endmodule
`default_nettype wire
